>>> rtl/config_lexer_unit_defines.svh
// ----------------------------------------------------------------------------
// config_lexer_unit_defines
// assertion macros used by the config_lexer_unit rtl
// ----------------------------------------------------------------------------
`ifndef CONFIG_LEXER_UNIT_DEFINES_SVH
`define CONFIG_LEXER_UNIT_DEFINES_SVH

// same-cycle implication
`define CFL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cfl_pkg.sv
// ----------------------------------------------------------------------------
// cfl_pkg
// types, constants and helpers for the config lexer
// ----------------------------------------------------------------------------
package cfl_pkg;

    localparam int POS_BITS   = 16;
    localparam int OUT_BITS   = 16;
    localparam int TYPE_BITS  = 4;
    localparam int KW_BITS    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam int DATA_BITS  = ((TYPE_BITS + 4 * OUT_BITS) + 7) / 8 * 8;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [OUT_BITS-1:0] t_out;
    typedef logic [TYPE_BITS-1:0] t_tok;

    localparam t_tok TT_EXIT    = 4'd0;
    localparam t_tok TT_SEMI    = 4'd1;
    localparam t_tok TT_COMMA   = 4'd2;
    localparam t_tok TT_INT     = 4'd3;
    localparam t_tok TT_STRING  = 4'd4;
    localparam t_tok TT_IDENT   = 4'd5;
    localparam t_tok TT_END     = 4'd6;
    localparam t_tok TT_BAD     = 4'd7;
    localparam t_tok TT_UNTERM  = 4'd8;

    localparam logic [KW_BITS-1:0] KW_DONE = 3'd4;
    localparam logic [KW_BITS-1:0] KW_FAIL = 3'd7;

    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    typedef enum logic [5:0] {
        M_BETWEEN = 6'b000001,
        M_COMMENT = 6'b000010,
        M_INT     = 6'b000100,
        M_STR     = 6'b001000,
        M_IDENT   = 6'b010000,
        M_HALT    = 6'b100000
    } t_mode;

    typedef struct packed {
        logic last;
        t_out column;
        t_out line;
        t_out length;
        t_out start;
        t_tok kind;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_emit;

    function automatic t_pos sat_inc(input t_pos x);
        return (x == '1) ? x : t_pos'(x + 1'b1);
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        case (idx)
            2'd0:    return 8'h65;
            2'd1:    return 8'h78;
            2'd2:    return 8'h69;
            default: return 8'h74;
        endcase
    endfunction

    function automatic t_result make_result(input t_tok kind, input t_pos start,
                                            input t_pos length, input t_pos line,
                                            input t_pos column);
        t_result r;
        r.kind   = kind;
        r.start  = t_out'(start);
        r.length = t_out'(length);
        r.line   = t_out'(line);
        r.column = t_out'(column);
        r.last   = 1'b1;
        return r;
    endfunction

endpackage

>>> rtl/cfl_scan.sv
// ----------------------------------------------------------------------------
// cfl_scan
// scanner state and per-byte token decisions, up to two results per byte
// ----------------------------------------------------------------------------
module cfl_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output cfl_pkg::t_emit o_emit
);
    import cfl_pkg::*;

    t_mode               r_mode, n_mode;
    t_pos                r_off, n_off;
    t_pos                r_line, n_line;
    t_pos                r_col, n_col;
    t_pos                r_ps, n_ps;
    t_pos                r_pl, n_pl;
    t_pos                r_pc, n_pc;
    logic [KW_BITS-1:0]  r_kw, n_kw;

    logic    is_end, is_nl, is_ws, is_digit, is_alpha;
    logic    go_between, rst_all, adv;
    logic    tok_a_v, tok_b_v;
    t_result tok_a, tok_b;
    t_pos    adv_off, adv_line, adv_col;

    assign is_end   = (i_byte == CH_END);
    assign is_nl    = (i_byte == CH_LF) || (i_byte == CH_CR);
    assign is_ws    = is_nl || (i_byte == CH_SPACE) || (i_byte == CH_TAB);
    assign is_digit = (i_byte inside {[8'h30:8'h39]});
    assign is_alpha = (i_byte inside {[8'h61:8'h7a], [8'h41:8'h5a]}) ||
                      (i_byte == CH_UNDER);

    assign adv_off  = sat_inc(r_off);
    assign adv_line = is_nl ? sat_inc(r_line) : r_line;
    assign adv_col  = is_nl ? t_pos'(1) : sat_inc(r_col);

    always_comb begin
        n_mode     = r_mode;
        n_ps       = r_ps;
        n_pl       = r_pl;
        n_pc       = r_pc;
        n_kw       = r_kw;
        go_between = 1'b0;
        rst_all    = 1'b0;
        adv        = 1'b0;
        tok_a_v    = 1'b0;
        tok_b_v    = 1'b0;
        tok_a      = '0;
        tok_b      = '0;

        case (r_mode)
            M_HALT: begin
                rst_all = is_end;
            end
            M_COMMENT: begin
                if (is_end) begin
                    go_between = 1'b1;
                end else begin
                    adv = 1'b1;
                    if (i_byte == CH_LF) begin
                        n_mode = M_BETWEEN;
                    end
                end
            end
            M_STR: begin
                if (is_end) begin
                    tok_a_v = 1'b1;
                    tok_a   = make_result(TT_UNTERM, r_off, '0, r_line, r_col);
                    rst_all = 1'b1;
                end else if (i_byte == CH_QUOTE) begin
                    tok_a_v = 1'b1;
                    tok_a   = make_result(TT_STRING, r_ps, sat_inc(t_pos'(r_off - r_ps)),
                                          r_pl, r_pc);
                    n_mode  = M_BETWEEN;
                    adv     = 1'b1;
                end else begin
                    adv = 1'b1;
                end
            end
            M_INT: begin
                if (is_digit) begin
                    adv = 1'b1;
                end else begin
                    tok_a_v    = 1'b1;
                    tok_a      = make_result(TT_INT, r_ps, t_pos'(r_off - r_ps), r_pl, r_pc);
                    go_between = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_digit || is_alpha) begin
                    adv = 1'b1;
                    if ((r_kw < KW_DONE) && (i_byte == kw_char(r_kw[1:0]))) begin
                        n_kw = r_kw + 1'b1;
                    end else begin
                        n_kw = KW_FAIL;
                    end
                end else begin
                    tok_a_v    = 1'b1;
                    tok_a      = make_result((r_kw == KW_DONE) ? TT_EXIT : TT_IDENT, r_ps,
                                             t_pos'(r_off - r_ps), r_pl, r_pc);
                    go_between = 1'b1;
                end
            end
            M_BETWEEN: begin
                go_between = 1'b1;
            end
            default: begin
                go_between = 1'b1;
            end
        endcase

        if (go_between) begin
            n_mode = M_BETWEEN;
            if (is_end) begin
                tok_b_v = 1'b1;
                tok_b   = make_result(TT_END, r_off, '0, r_line, r_col);
                rst_all = 1'b1;
            end else if (is_ws) begin
                adv = 1'b1;
            end else if (i_byte == CH_HASH) begin
                n_mode = M_COMMENT;
                adv    = 1'b1;
            end else if ((i_byte == CH_SEMI) || (i_byte == CH_COMMA)) begin
                tok_b_v = 1'b1;
                tok_b   = make_result((i_byte == CH_SEMI) ? TT_SEMI : TT_COMMA, r_off,
                                      t_pos'(1), r_line, r_col);
                adv     = 1'b1;
            end else if ((i_byte == CH_QUOTE) || is_digit || is_alpha) begin
                n_ps = r_off;
                n_pl = r_line;
                n_pc = r_col;
                adv  = 1'b1;
                if (i_byte == CH_QUOTE) begin
                    n_mode = M_STR;
                end else if (is_digit) begin
                    n_mode = M_INT;
                end else begin
                    n_mode = M_IDENT;
                    n_kw   = (i_byte == kw_char(2'd0)) ? KW_BITS'(1) : KW_FAIL;
                end
            end else begin
                tok_b_v = 1'b1;
                tok_b   = make_result(TT_BAD, r_off, '0, r_line, r_col);
                n_mode  = M_HALT;
            end
        end
    end

    always_comb begin
        n_off  = adv ? adv_off  : r_off;
        n_line = adv ? adv_line : r_line;
        n_col  = adv ? adv_col  : r_col;
    end

    // first slot takes the closed token if any, else the token of this byte; second the token of this byte
    always_comb begin
        o_emit.count       = {1'b0, tok_a_v} + {1'b0, tok_b_v};
        o_emit.first       = tok_a_v ? tok_a : tok_b;
        o_emit.first.last  = !(tok_a_v && tok_b_v);
        o_emit.second      = tok_b;
        o_emit.second.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
            r_off  <= '0;
            r_line <= t_pos'(1);
            r_col  <= t_pos'(1);
            r_ps   <= '0;
            r_pl   <= t_pos'(1);
            r_pc   <= t_pos'(1);
            r_kw   <= '0;
        end else if (i_accept) begin
            if (rst_all) begin
                r_mode <= M_BETWEEN;
                r_off  <= '0;
                r_line <= t_pos'(1);
                r_col  <= t_pos'(1);
                r_ps   <= '0;
                r_pl   <= t_pos'(1);
                r_pc   <= t_pos'(1);
                r_kw   <= '0;
            end else begin
                r_mode <= n_mode;
                r_off  <= n_off;
                r_line <= n_line;
                r_col  <= n_col;
                r_ps   <= n_ps;
                r_pl   <= n_pl;
                r_pc   <= n_pc;
                r_kw   <= n_kw;
            end
        end
    end

endmodule

>>> rtl/cfl_fifo.sv
// ----------------------------------------------------------------------------
// cfl_fifo
// small result queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module cfl_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  cfl_pkg::t_result i_d0,
    input  cfl_pkg::t_result i_d1,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output cfl_pkg::t_result o_data
);
    import cfl_pkg::*;

    t_result                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wp, n_wp;
    logic [FIFO_PTR_BITS-1:0] r_rp, n_rp;
    logic [FIFO_CNT_BITS-1:0] r_count, n_count;
    logic [FIFO_PTR_BITS-1:0] wp_next;
    logic                     pop_ok;

    assign o_room  = (r_count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign pop_ok  = i_pop && o_valid;
    assign wp_next = r_wp + 1'b1;

    always_comb begin
        n_wp    = r_wp + FIFO_PTR_BITS'(i_push_cnt);
        n_rp    = r_rp + FIFO_PTR_BITS'(pop_ok);
        n_count = r_count + FIFO_CNT_BITS'(i_push_cnt) - FIFO_CNT_BITS'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_d0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp_next] <= i_d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/config_lexer_unit.sv
// ----------------------------------------------------------------------------
// config_lexer_unit
// byte-serial tokenizer for a small configuration language
//
//   channel   dir  fields (low bit up)
//   s_axis    in   tdata[7:0] byte_req
//   m_axis    out  tdata: token_type, start_offset, token_length,
//                  start_line, start_column; tlast: last
//
// one source byte accepted per cycle unless stalled; the scanner decides in the
// accept cycle and writes its zero, one or two results into a four-entry result
// queue. a byte can yield two results, so the input stalls when fewer than two
// queue slots are free. synchronous active-low reset returns the scanner to its
// start state and empties the queue.
// ----------------------------------------------------------------------------
`include "config_lexer_unit_defines.svh"

module config_lexer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // byte_req
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // token_type, start_offset, token_length, start_line, start_column
    output logic [cfl_pkg::DATA_BITS-1:0]    m_axis_tdata,
    output logic                             m_axis_tlast   // last
);
    import cfl_pkg::*;

    logic    in_accept;
    t_emit   emit;
    t_result head;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    cfl_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .o_emit   (emit)
    );

    cfl_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (in_accept ? emit.count : 2'd0),
        .i_d0       (emit.first),
        .i_d1       (emit.second),
        .i_pop      (m_axis_tready),
        .o_room     (s_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_data     (head)
    );

    assign m_axis_tdata = DATA_BITS'({head.column, head.line, head.length,
                                      head.start, head.kind});
    assign m_axis_tlast = head.last;

    `CFL_ASSERT_NEXT(a_pair_kept, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "second result of a byte missing")
    `CFL_ASSERT_SAME(a_end_last, i_clk, i_rst_n, m_axis_tvalid && (head.kind == TT_END || head.kind == TT_BAD || head.kind == TT_UNTERM), m_axis_tlast, "end or error result not marked last")
    `CFL_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid, "input stalled with empty result queue")

endmodule
